// File: design/hpsd_pkg.sv
// ----------------------------------------------------------------------------
// HPACK Huffman string decoder package
// Beat types, control structs, state encoding and the canonical code tables.
// ----------------------------------------------------------------------------
package hpsd_pkg;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] decoded_symbol;
        logic       symbol_present;
        logic       string_done;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // Symbol found by the bit decoder in the current cycle.
    typedef struct packed {
        logic       valid;
        logic [7:0] symbol;
    } hit_t;

    typedef struct packed {
        logic start;
        logic final_byte;
        logic emit;
    } q_ctl_t;

    typedef struct packed {
        logic has_result;
        logic drained;
    } q_status_t;

    localparam logic [4:0] CODE_MAX_LEN = 5'd30;

    // Number of codes of each length, indexed by length.
    localparam logic [5:0] LEN_COUNT [32] = '{
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd10, 6'd26, 6'd32,
        6'd6,  6'd0,  6'd5,  6'd3,  6'd2,  6'd6,  6'd2,  6'd3,
        6'd0,  6'd0,  6'd0,  6'd3,  6'd8,  6'd13, 6'd26, 6'd29,
        6'd12, 6'd4,  6'd15, 6'd19, 6'd29, 6'd0,  6'd3,  6'd0
    };

    // Position in CANON_SYM of the first code of each length.
    localparam logic [7:0] LEN_OFFSET [32] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd10,  8'd36,
        8'd68,  8'd74,  8'd74,  8'd79,  8'd82,  8'd84,  8'd90,  8'd92,
        8'd95,  8'd95,  8'd95,  8'd95,  8'd98,  8'd106, 8'd119, 8'd145,
        8'd174, 8'd186, 8'd190, 8'd205, 8'd224, 8'd253, 8'd253, 8'd0
    };

    // Symbols in canonical order: by code length, then by symbol value.
    localparam logic [7:0] CANON_SYM [256] = '{
        // length 5
        8'd48,  8'd49,  8'd50,  8'd97,  8'd99,  8'd101, 8'd105, 8'd111,
        8'd115, 8'd116,
        // length 6
        8'd32,  8'd37,  8'd45,  8'd46,  8'd47,  8'd51,  8'd52,  8'd53,
        8'd54,  8'd55,  8'd56,  8'd57,  8'd61,  8'd65,  8'd95,  8'd98,
        8'd100, 8'd102, 8'd103, 8'd104, 8'd108, 8'd109, 8'd110, 8'd112,
        8'd114, 8'd117,
        // length 7
        8'd58,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
        8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,
        8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd89,
        8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122,
        // length 8
        8'd38,  8'd42,  8'd44,  8'd59,  8'd88,  8'd90,
        // length 10
        8'd33,  8'd34,  8'd40,  8'd41,  8'd63,
        // length 11
        8'd39,  8'd43,  8'd124,
        // length 12
        8'd35,  8'd62,
        // length 13
        8'd0,   8'd36,  8'd64,  8'd91,  8'd93,  8'd126,
        // length 14
        8'd94,  8'd125,
        // length 15
        8'd60,  8'd96,  8'd123,
        // length 19
        8'd92,  8'd195, 8'd208,
        // length 20
        8'd128, 8'd130, 8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226,
        // length 21
        8'd153, 8'd161, 8'd167, 8'd172, 8'd176, 8'd177, 8'd179, 8'd209,
        8'd216, 8'd217, 8'd227, 8'd229, 8'd230,
        // length 22
        8'd129, 8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156,
        8'd160, 8'd163, 8'd164, 8'd169, 8'd170, 8'd173, 8'd178, 8'd181,
        8'd185, 8'd186, 8'd187, 8'd189, 8'd190, 8'd196, 8'd198, 8'd228,
        8'd232, 8'd233,
        // length 23
        8'd1,   8'd135, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd143,
        8'd147, 8'd149, 8'd150, 8'd151, 8'd152, 8'd155, 8'd157, 8'd158,
        8'd165, 8'd166, 8'd168, 8'd174, 8'd175, 8'd180, 8'd182, 8'd183,
        8'd188, 8'd191, 8'd197, 8'd231, 8'd239,
        // length 24
        8'd9,   8'd142, 8'd144, 8'd145, 8'd148, 8'd159, 8'd171, 8'd206,
        8'd215, 8'd225, 8'd236, 8'd237,
        // length 25
        8'd199, 8'd207, 8'd234, 8'd235,
        // length 26
        8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213,
        8'd218, 8'd219, 8'd238, 8'd240, 8'd242, 8'd243, 8'd255,
        // length 27
        8'd203, 8'd204, 8'd211, 8'd212, 8'd214, 8'd221, 8'd222, 8'd223,
        8'd241, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd250, 8'd251,
        8'd252, 8'd253, 8'd254,
        // length 28
        8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd11,
        8'd12,  8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd19,  8'd20,
        8'd21,  8'd23,  8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,
        8'd30,  8'd31,  8'd127, 8'd220, 8'd249,
        // length 30
        8'd10,  8'd13,  8'd22
    };

endpackage

// File: design/hpack_huffman_string_decoder_unit.sv
// ----------------------------------------------------------------------------
// HPACK Huffman string decoder unit
// Decodes an HPACK Huffman-coded header string one coded byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   code channel: one beat per coded byte (coded_byte, final_byte). The byte
//   is decoded MSB first, one bit per cycle, through an 8-bit shift register.
//   sym channel: one beat per decoded octet. A final byte always ends with a
//   beat carrying string_done; if it completes no code, that beat has
//   symbol_present low. A byte may yield zero, one or two beats.
// Timing:
//   A byte is taken while the unit is idle and then shifted through the
//   decoder bit by bit; its result beats, if any, are played out after the
//   last bit. The single-bit decode loop limits the throughput.
//   The unit holds code_stall high after acceptance until the byte is
//   shifted out and its last result beat, if any, has been taken.
// Reset:
//   rst_n clears the code accumulator, the result queue and the sequencer;
//   the first byte can be sent right after reset is released.
// Stall:
//   While sym_stall is high during a result beat, that beat holds steady and
//   no new coded byte is accepted.
// ----------------------------------------------------------------------------
module hpack_huffman_string_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                code_valid,
    output logic                code_stall,
    input  hpsd_pkg::in_beat_t  code_data,
    output logic                sym_valid,
    input  logic                sym_stall,
    output hpsd_pkg::out_beat_t sym_data
);
    import hpsd_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg,   shift_next;
    logic       final_reg,   final_next;

    logic       code_taken;
    logic       last_bit;
    logic       bit_valid;
    logic       flush;
    hit_t       hit;
    q_ctl_t     q_ctl;
    q_status_t  q_status;

    hpsd_bit_decoder u_bit_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_valid (bit_valid),
        .code_bit  (shift_reg[7]),
        .flush     (flush),
        .hit       (hit)
    );

    hpsd_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .hit       (hit),
        .sym_stall (sym_stall),
        .sym_valid (sym_valid),
        .sym_data  (sym_data),
        .status    (q_status)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (code_valid)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (bit_cnt_reg == 3'd7)
                begin
                    if (final_reg || hit.valid || q_status.has_result)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (q_status.drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath controls.
    always_comb
    begin
        code_stall  = state_reg != ST_IDLE;
        code_taken  = code_valid && !code_stall;
        bit_valid   = state_reg == ST_SHIFT;
        last_bit    = bit_cnt_reg == 3'd7;
        flush       = final_reg && last_bit;

        q_ctl.start      = code_taken;
        q_ctl.final_byte = code_data.final_byte;
        q_ctl.emit       = state_reg == ST_EMIT;

        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        final_next   = final_reg;
        if (code_taken)
        begin
            bit_cnt_next = '0;
            shift_next   = code_data.coded_byte;
            final_next   = code_data.final_byte;
        end
        else if (bit_valid)
        begin
            bit_cnt_next = bit_cnt_reg + 3'd1;
            shift_next   = {shift_reg[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            final_reg   <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // A new byte always starts at its first bit.
    a_start_shift: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_stall |=> (state_reg == ST_SHIFT) && (bit_cnt_reg == 3'd0))
        else $error("accepted byte did not start shifting at bit zero");

    // The shortest code is five bits, so two symbols never complete back to back.
    a_hit_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid |=> !hit.valid)
        else $error("symbols completed on consecutive bits");

    // Result beats are only played out when there is something to report.
    a_emit_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (q_status.has_result || final_reg))
        else $error("result phase entered with nothing to deliver");

    // The end-of-string beat is the last beat of its byte.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_stall && sym_data.string_done |=> (state_reg == ST_IDLE))
        else $error("unit still busy after the end-of-string beat");

endmodule

// File: design/hpsd_bit_decoder.sv
// ----------------------------------------------------------------------------
// HPACK Huffman bit decoder
// Walks the canonical code one bit per cycle while bit_valid is high, keeping
// only the current length and how far the prefix lies past the last code of that length.
// ----------------------------------------------------------------------------
module hpsd_bit_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          bit_valid,
    input  logic          code_bit,
    input  logic          flush,
    output hpsd_pkg::hit_t hit
);
    import hpsd_pkg::*;

    // Because the code tree is complete, the prefix never falls below the
    // first code of its length and the residue stays well under 64.
    logic [5:0] resid_reg, resid_next;
    logic [4:0] len_reg,   len_next;

    logic [4:0] cur_len;
    logic [6:0] cur_dist;
    logic [5:0] cur_count;
    logic       match;
    logic [7:0] sym_index;

    always_comb
    begin
        cur_len   = len_reg + 5'd1;
        cur_dist  = {resid_reg, code_bit};
        cur_count = LEN_COUNT[cur_len];
        match     = cur_dist < {1'b0, cur_count};
        sym_index = LEN_OFFSET[cur_len] + {1'b0, cur_dist};
    end

    always_comb
    begin
        hit.valid  = bit_valid && match;
        hit.symbol = CANON_SYM[sym_index];
    end

    always_comb
    begin
        resid_next = resid_reg;
        len_next   = len_reg;
        if (bit_valid)
        begin
            if (flush || match || (cur_len == CODE_MAX_LEN))
            begin
                resid_next = '0;
                len_next   = '0;
            end
            else
            begin
                resid_next = 6'(cur_dist - {1'b0, cur_count});
                len_next   = cur_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resid_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            resid_reg <= resid_next;
            len_reg   <= len_next;
        end
    end

endmodule

// File: design/hpsd_result_queue.sv
// ----------------------------------------------------------------------------
// HPACK Huffman result queue
// Collects the symbols of one coded byte and plays them out as result beats,
// marking the end of the string on the last beat of a final byte.
// ----------------------------------------------------------------------------
module hpsd_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  hpsd_pkg::q_ctl_t    ctl,
    input  hpsd_pkg::hit_t      hit,
    input  logic                sym_stall,
    output logic                sym_valid,
    output hpsd_pkg::out_beat_t sym_data,
    output hpsd_pkg::q_status_t status
);
    import hpsd_pkg::*;

    logic [7:0] slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg,  rd_next;
    logic       fin_reg, fin_next;

    logic       present;
    logic       last_beat;
    logic       beat_taken;

    always_comb
    begin
        present    = cnt_reg != 2'd0;
        // A final byte with no symbol still yields one beat that closes the string.
        last_beat  = !present || (({1'b0, rd_reg} + 2'd1) == cnt_reg);
        beat_taken = ctl.emit && !sym_stall;

        sym_valid               = ctl.emit;
        sym_data.decoded_symbol = present ? slot_reg[rd_reg] : 8'd0;
        sym_data.symbol_present = present;
        sym_data.string_done    = fin_reg && last_beat;

        status.has_result = present;
        status.drained    = beat_taken && last_beat;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        fin_next = fin_reg;
        if (ctl.start)
        begin
            cnt_next = '0;
            rd_next  = 1'b0;
            fin_next = ctl.final_byte;
        end
        else if (hit.valid && (cnt_reg != 2'd2))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (beat_taken && !last_beat)
        begin
            rd_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.start && hit.valid && (cnt_reg != 2'd2))
        begin
            slot_reg[cnt_reg[0]] <= hit.symbol;
        end
    end

endmodule
